// ===== hw/rtl/fvtp_pkg.sv =====
// Shared types, constants and the sine and cosine tables for the dq to PWM pipeline.
package fvtp_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PWM_BITS         = 16;

  localparam int IDX_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam int TRIG_W     = 16;
  localparam int VOLT_W     = 16;
  localparam int CMP_W      = 16;
  localparam int POLE_W     = 7;
  localparam int RECIP_W    = 24;
  localparam int CFG_DATA_W = 24;

  // Datapath widths
  localparam int PROD_W  = VOLT_W + TRIG_W;       // one dq by trig product
  localparam int AB_W    = PROD_W + 1;            // alpha and beta
  localparam int SQ3_W   = 17;                    // sqrt3/2 in Q16, unsigned
  localparam int BK_W    = AB_W + SQ3_W;          // beta times sqrt3/2
  localparam int PHS_W   = AB_W + 1;              // phase voltage, Q15 mV
  localparam int DPROD_W = PHS_W + RECIP_W + 1;   // phase times bus reciprocal
  localparam int DUTY_W  = 40;                    // clamped duty, Q39, up to one
  localparam int CPROD_W = DUTY_W + CMP_W;        // duty times period

  localparam logic [SQ3_W-1:0]  SQRT3_HALF_Q16 = SQ3_W'(56756);
  localparam logic [63:0]       Q30_PI         = 64'd3373259426;
  localparam logic [63:0]       Q30_HALF_PI    = 64'd1686629713;
  localparam logic [63:0]       Q30_TWO_PI     = 64'd6746518852;
  localparam logic [CMP_W-1:0]  CMP_MAX        = CMP_W'((64'd1 << PWM_BITS) - 64'd1);

  typedef enum logic [1:0] {
    CFG_POLE_PAIRS     = 2'd0,
    CFG_ANGLE_OFFSET   = 2'd1,
    CFG_BUS_RECIPROCAL = 2'd2,
    CFG_PWM_PERIOD     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        [ANGLE_BITS-1:0] mech_angle;
    logic signed [VOLT_W-1:0]     volt_q;
    logic signed [VOLT_W-1:0]     volt_d;
  } fvtp_req_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic [CMP_W-1:0] compare_c;
  } fvtp_res_t;

  typedef logic [SINE_TABLE_DEPTH-1:0][TRIG_W-1:0] trig_lut_t;

  // Sine of a Q30 angle below 2.5 pi as Q1.15: fold to a quarter turn, Taylor to x^15
  function automatic logic [TRIG_W-1:0] sine_q15(input logic [63:0] x_in);
    logic [63:0]        x;
    logic [63:0]        m;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    logic               neg;
    x   = x_in;
    neg = 1'b0;
    if (x >= Q30_TWO_PI) begin
      x = x - Q30_TWO_PI;
    end
    if (x >= Q30_PI) begin
      neg = 1'b1;
      x   = x - Q30_PI;
    end
    if (x > Q30_HALF_PI) begin
      x = Q30_PI - x;
    end
    m    = x;
    term = m;
    sum  = $signed(m);
    for (int n = 1; n <= 7; n++) begin
      term = (((term * m) >> 30) * m) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return neg ? (TRIG_W'(0) - r[TRIG_W-1:0]) : r[TRIG_W-1:0];
  endfunction

  function automatic trig_lut_t build_lut(input logic quarter);
    trig_lut_t   lut;
    logic [63:0] x;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x = 64'(k) * Q30_TWO_PI / 64'(SINE_TABLE_DEPTH);
      lut[k] = sine_q15(quarter ? (x + Q30_HALF_PI) : x);
    end
    return lut;
  endfunction

  localparam trig_lut_t SIN_LUT = build_lut(1'b0);
  localparam trig_lut_t COS_LUT = build_lut(1'b1);

endpackage

// ===== hw/rtl/fvtp_sincos.sv =====
// Sine and cosine table lookup with registered read data.
module fvtp_sincos (
  input  logic                                  clk_i,
  input  logic [fvtp_pkg::ANGLE_BITS-1:0]       theta_i,
  output logic signed [fvtp_pkg::TRIG_W-1:0]    sin_o,
  output logic signed [fvtp_pkg::TRIG_W-1:0]    cos_o
);
  import fvtp_pkg::*;

  logic [IDX_BITS-1:0]      idx;
  logic signed [TRIG_W-1:0] sin_q;
  logic signed [TRIG_W-1:0] cos_q;

  // Top bits of the turn fraction pick the entry
  assign idx = theta_i[ANGLE_BITS-1 -: IDX_BITS];

  always_ff @(posedge clk_i) begin
    sin_q <= $signed(SIN_LUT[idx]);
    cos_q <= $signed(COS_LUT[idx]);
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== hw/rtl/fvtp_compare.sv =====
// One phase: bus scaling, half offset, duty clamp and period scaling over four stages.
module fvtp_compare (
  input  logic                                  clk_i,
  input  logic signed [fvtp_pkg::PHS_W-1:0]     phase_i,
  input  logic [fvtp_pkg::RECIP_W-1:0]          bus_reciprocal_i,
  input  logic [fvtp_pkg::CMP_W-1:0]            pwm_period_i,
  output logic [fvtp_pkg::CMP_W-1:0]            compare_o
);
  import fvtp_pkg::*;

  localparam int SUM_W = DPROD_W + 1;
  localparam logic signed [SUM_W-1:0] DUTY_HALF = SUM_W'(64'd1 << 38);
  localparam logic signed [SUM_W-1:0] DUTY_ONE  = SUM_W'(64'd1 << 39);

  logic signed [RECIP_W:0]    recip_s;
  logic signed [DPROD_W-1:0]  dprod_d, dprod_q;
  logic signed [SUM_W-1:0]    dsum;
  logic [DUTY_W-1:0]          duty_d, duty_q;
  logic [CPROD_W-1:0]         cprod_d, cprod_q;
  logic [CPROD_W-40:0]        cmp_full;
  logic [CMP_W-1:0]           cmp_d, cmp_q;

  assign recip_s = $signed({1'b0, bus_reciprocal_i});
  assign dprod_d = DPROD_W'(phase_i) * DPROD_W'(recip_s);

  always_comb begin
    dsum = SUM_W'(dprod_q) + DUTY_HALF;
    if (dsum < 0) begin
      duty_d = '0;
    end else if (dsum > DUTY_ONE) begin
      duty_d = DUTY_W'(DUTY_ONE);
    end else begin
      duty_d = DUTY_W'(dsum);
    end
  end

  assign cprod_d  = CPROD_W'(duty_q) * CPROD_W'(pwm_period_i);
  assign cmp_full = cprod_q[CPROD_W-1:39];

  // Saturate at the PWM counter range
  assign cmp_d = (cmp_full > (CPROD_W-39)'(CMP_MAX)) ? CMP_MAX : CMP_W'(cmp_full);

  always_ff @(posedge clk_i) begin
    dprod_q <= dprod_d;
    duty_q  <= duty_d;
    cprod_q <= cprod_d;
    cmp_q   <= cmp_d;
  end

  assign compare_o = cmp_q;

endmodule

// ===== hw/rtl/foc_voltage_to_three_phase_pwm.sv =====
// Top level: dq voltage demand and rotor angle to three PWM compare values.
//
//   Channel   Handshake             Payload
//   request   start_i / busy_o      req_i    (mech_angle, volt_q, volt_d)
//   result    done_o (one cycle)    result_o (compare_a, compare_b, compare_c)
//   config    cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// Ten register stages: angle, table read, four products, alpha/beta, beta scaling,
// phase voltages, then four stages per phase for duty and compare. A request is
// taken every cycle; busy_o stays low and each result leaves the last stage along
// with done_o. Reset clears the valid pipeline and loads the default register
// values. The receiver cannot stall, so nothing holds the pipeline.
module foc_voltage_to_three_phase_pwm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  fvtp_pkg::fvtp_req_t                req_i,
  output logic                               done_o,
  output fvtp_pkg::fvtp_res_t                result_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [fvtp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import fvtp_pkg::*;

  localparam int TAIL = 4;

  // Configuration
  logic [POLE_W-1:0]     pole_pairs_q;
  logic [ANGLE_BITS-1:0] angle_offset_q;
  logic [RECIP_W-1:0]    bus_reciprocal_q;
  logic [CMP_W-1:0]      pwm_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pairs_q     <= POLE_W'(7);
      angle_offset_q   <= ANGLE_BITS'(28995);
      bus_reciprocal_q <= RECIP_W'(1398);
      pwm_period_q     <= CMP_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLE_PAIRS:     pole_pairs_q     <= cfg_wdata_i[POLE_W-1:0];
        CFG_ANGLE_OFFSET:   angle_offset_q   <= cfg_wdata_i[ANGLE_BITS-1:0];
        CFG_BUS_RECIPROCAL: bus_reciprocal_q <= cfg_wdata_i[RECIP_W-1:0];
        CFG_PWM_PERIOD:     pwm_period_q     <= cfg_wdata_i[CMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits
  logic            v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [TAIL-1:0] vtail_q;
  logic            accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      vtail_q <= '0;
    end else begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      vtail_q <= {vtail_q[TAIL-2:0], v6_q};
    end
  end

  // Stage 1: electrical angle, wrapped to one turn
  logic [ANGLE_BITS+POLE_W-1:0] theta_full;
  logic [ANGLE_BITS-1:0]        theta_q;
  logic signed [VOLT_W-1:0]     vq1_q, vd1_q;

  assign theta_full = (ANGLE_BITS+POLE_W)'(req_i.mech_angle) * (ANGLE_BITS+POLE_W)'(pole_pairs_q)
                    + (ANGLE_BITS+POLE_W)'(angle_offset_q);

  always_ff @(posedge clk_i) begin
    theta_q <= theta_full[ANGLE_BITS-1:0];
    vq1_q   <= req_i.volt_q;
    vd1_q   <= req_i.volt_d;
  end

  // Stage 2: table read
  logic signed [TRIG_W-1:0] sin_w, cos_w;
  logic signed [VOLT_W-1:0] vq2_q, vd2_q;

  fvtp_sincos u_sincos (
    .clk_i   (clk_i),
    .theta_i (theta_q),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  always_ff @(posedge clk_i) begin
    vq2_q <= vq1_q;
    vd2_q <= vd1_q;
  end

  // Stage 3: products
  logic signed [PROD_W-1:0] pdc_q, pqs_q, pds_q, pqc_q;

  always_ff @(posedge clk_i) begin
    pdc_q <= PROD_W'(vd2_q) * PROD_W'(cos_w);
    pqs_q <= PROD_W'(vq2_q) * PROD_W'(sin_w);
    pds_q <= PROD_W'(vd2_q) * PROD_W'(sin_w);
    pqc_q <= PROD_W'(vq2_q) * PROD_W'(cos_w);
  end

  // Stage 4: inverse Park
  logic signed [AB_W-1:0] alpha4_q, beta4_q;

  always_ff @(posedge clk_i) begin
    alpha4_q <= AB_W'(pdc_q) - AB_W'(pqs_q);
    beta4_q  <= AB_W'(pds_q) + AB_W'(pqc_q);
  end

  // Stage 5: beta times sqrt3/2
  logic signed [SQ3_W:0]  sq3_s;
  logic signed [AB_W-1:0] alpha5_q;
  logic signed [BK_W-1:0] betak_q;

  assign sq3_s = $signed({1'b0, SQRT3_HALF_Q16});

  always_ff @(posedge clk_i) begin
    alpha5_q <= alpha4_q;
    betak_q  <= BK_W'(beta4_q) * BK_W'(sq3_s);
  end

  // Stage 6: inverse Clarke; phases b and c floored from Q31 to Q15, phase a passed as Q15
  localparam int CS_W = BK_W + 1;

  logic signed [CS_W-1:0]  alpha_half;
  logic signed [CS_W-1:0]  sum_b, sum_c;
  logic signed [PHS_W-1:0] pha_q, phb_q, phc_q;

  assign alpha_half = CS_W'(alpha5_q) <<< 15;
  assign sum_b      = CS_W'(betak_q) - alpha_half;
  assign sum_c      = -alpha_half - CS_W'(betak_q);

  always_ff @(posedge clk_i) begin
    pha_q <= PHS_W'(alpha5_q);
    phb_q <= PHS_W'(sum_b >>> 16);
    phc_q <= PHS_W'(sum_c >>> 16);
  end

  // Stages 7 to 10: per-phase duty and compare
  logic [CMP_W-1:0] cmp_a, cmp_b, cmp_c;

  fvtp_compare u_cmp_a (
    .clk_i            (clk_i),
    .phase_i          (pha_q),
    .bus_reciprocal_i (bus_reciprocal_q),
    .pwm_period_i     (pwm_period_q),
    .compare_o        (cmp_a)
  );

  fvtp_compare u_cmp_b (
    .clk_i            (clk_i),
    .phase_i          (phb_q),
    .bus_reciprocal_i (bus_reciprocal_q),
    .pwm_period_i     (pwm_period_q),
    .compare_o        (cmp_b)
  );

  fvtp_compare u_cmp_c (
    .clk_i            (clk_i),
    .phase_i          (phc_q),
    .bus_reciprocal_i (bus_reciprocal_q),
    .pwm_period_i     (pwm_period_q),
    .compare_o        (cmp_c)
  );

  assign done_o             = vtail_q[TAIL-1];
  assign result_o.compare_a = cmp_a;
  assign result_o.compare_b = cmp_b;
  assign result_o.compare_c = cmp_c;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the dq voltage to three-phase PWM compare pipeline.
`timescale 1ns / 100ps

module testbench;
  import fvtp_pkg::*;

  localparam int          SETTLE_CYCLES  = 16;      // pipeline is ten deep
  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          ITEMS_PER_SET  = 88;
  localparam longint      TURN_Q30       = 64'd6746518852;
  localparam longint      HALF_TURN_Q30  = 64'd3373259426;
  localparam longint      QUARTER_Q30    = 64'd1686629713;
  localparam longint      ROOT3_HALF_Q16 = 56756;
  localparam longint      DUTY_MID_Q39   = 64'sd1 <<< 38;
  localparam longint      DUTY_FULL_Q39  = 64'sd1 <<< 39;
  localparam logic [23:0] POLES_RST      = 24'd7;
  localparam logic [23:0] OFFSET_RST     = 24'd28995;
  localparam logic [23:0] RECIP_RST      = 24'd1398;
  localparam logic [23:0] PERIOD_RST     = 24'd1000;

  typedef struct {
    bit        is_write;
    cfg_reg_e  cfg_sel;
    logic [CFG_DATA_W-1:0] value;
    fvtp_req_t req;
    int        idle_pct;
  } pwm_job_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  fvtp_req_t             req_i       = '0;
  logic                  done_o;
  fvtp_res_t             result_o;
  logic                  cfg_we_i    = 1'b0;
  cfg_reg_e              cfg_idx_i   = CFG_POLE_PAIRS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  pwm_job_t  job_q[$];
  fvtp_res_t compares_due_q[$];

  longint sin_tab[SINE_TABLE_DEPTH];
  longint cos_tab[SINE_TABLE_DEPTH];

  // Register copies as the block should hold them
  longint poles_m, offset_m, recip_m, period_m;

  int fail_count   = 0;
  int quiet_cycles = 0;
  int cycle_count  = 0;

  foc_voltage_to_three_phase_pwm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Quarter-wave folded Taylor sine, Q30 radians in, Q1.15 out
  function automatic longint taylor_sine_q15(input longint unsigned ang);
    longint unsigned a;
    longint unsigned term;
    longint unsigned divisor;
    longint unsigned rounded;
    longint          acc;
    bit              negate;
    a      = ang;
    negate = 1'b0;
    while (a >= TURN_Q30) a = a - TURN_Q30;
    if (a >= HALF_TURN_Q30) begin
      negate = 1'b1;
      a      = a - HALF_TURN_Q30;
    end
    if (a > QUARTER_Q30) a = HALF_TURN_Q30 - a;
    term = a;
    acc  = longint'(a);
    for (int n = 1; n <= 7; n++) begin
      divisor = (2 * n) * (2 * n + 1);
      term    = (((term * a) >> 30) * a) >> 30;
      term    = term / divisor;
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    rounded = (longint'(acc) + 16384) >> 15;
    if (rounded > 32767) rounded = 32767;
    return negate ? -longint'(rounded) : longint'(rounded);
  endfunction

  function automatic logic [CMP_W-1:0] duty_to_compare(input longint phase_q31);
    longint          duty;
    longint unsigned cmp;
    duty = (phase_q31 >>> 16) * recip_m + DUTY_MID_Q39;
    if (duty < 0) duty = 0;
    if (duty > DUTY_FULL_Q39) duty = DUTY_FULL_Q39;
    cmp = (longint'(duty) * period_m) >>> 39;
    if (cmp > (64'd1 << PWM_BITS) - 1) cmp = (64'd1 << PWM_BITS) - 1;
    return cmp[CMP_W-1:0];
  endfunction

  function automatic fvtp_res_t predict_compares(input fvtp_req_t rq);
    logic [31:0] elec;
    int unsigned idx;
    longint      vq, vd, s, c, alpha, beta;
    fvtp_res_t   res;
    elec  = rq.mech_angle * poles_m[6:0] + offset_m[15:0];
    idx   = (32'(elec[ANGLE_BITS-1:0]) * SINE_TABLE_DEPTH) >> ANGLE_BITS;
    s     = sin_tab[idx];
    c     = cos_tab[idx];
    vq    = longint'($signed(rq.volt_q));
    vd    = longint'($signed(rq.volt_d));
    alpha = vd * c - vq * s;
    beta  = vd * s + vq * c;
    res.compare_a = duty_to_compare(alpha * 65536);
    res.compare_b = duty_to_compare(-alpha * 32768 + beta * ROOT3_HALF_Q16);
    res.compare_c = duty_to_compare(-alpha * 32768 - beta * ROOT3_HALF_Q16);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic queue_write(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] v);
    pwm_job_t job;
    job.is_write = 1'b1;
    job.cfg_sel  = sel;
    job.value    = v;
    job.req      = '0;
    job.idle_pct = 0;
    job_q.push_back(job);
  endtask

  task automatic queue_request(input logic [15:0] mech, input logic [15:0] vq,
                               input logic [15:0] vd, input int pct);
    pwm_job_t job;
    job.is_write       = 1'b0;
    job.cfg_sel        = CFG_POLE_PAIRS;
    job.value          = '0;
    job.req.mech_angle = mech;
    job.req.volt_q     = vq;
    job.req.volt_d     = vd;
    job.idle_pct       = pct;
    job_q.push_back(job);
  endtask

  function automatic logic [15:0] random_volt();
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = 16'($signed($urandom_range(8000)) - 4000);
      5, 6, 7:       v = 16'($urandom);
      8: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($signed($urandom_range(40000)) - 20000);
    endcase
    return v;
  endfunction

  task automatic queue_random_set(input int pct);
    for (int i = 0; i < ITEMS_PER_SET; i++) begin
      queue_request(16'($urandom), random_volt(), random_volt(), pct);
    end
  endtask

  task automatic queue_settings(input logic [CFG_DATA_W-1:0] poles,
                                input logic [CFG_DATA_W-1:0] offset,
                                input logic [CFG_DATA_W-1:0] recip,
                                input logic [CFG_DATA_W-1:0] period);
    queue_write(CFG_POLE_PAIRS, poles);
    queue_write(CFG_ANGLE_OFFSET, offset);
    queue_write(CFG_BUS_RECIPROCAL, recip);
    queue_write(CFG_PWM_PERIOD, period);
  endtask

  initial begin
    longint unsigned ang;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      ang        = longint'(k) * TURN_Q30 / SINE_TABLE_DEPTH;
      sin_tab[k] = taylor_sine_q15(ang);
      cos_tab[k] = taylor_sine_q15(ang + QUARTER_Q30);
    end

    // Reset settings: corners of the angle and voltage ranges, fixed points and a random set
    queue_request(16'd0,     16'h0000, 16'h0000, 0);
    queue_request(16'hFFFF,  16'h7FFF, 16'h7FFF, 0);
    queue_request(16'd0,     16'h8000, 16'h8000, 0);
    queue_request(16'h8000,  16'h7FFF, 16'h8000, 0);
    queue_request(16'd1,     16'h8000, 16'h7FFF, 0);
    queue_request(16'h4000,  16'hFFFF, 16'h0001, 0);
    queue_request(16'hC000,  16'h0000, 16'h0000, 0);
    for (int k = 0; k < 4; k++) begin
      queue_request(16'(k * 16384), 16'd1000, 16'd0, 0);
      queue_request(16'(k * 16384), 16'd0, 16'hFC18, 0);
      queue_request(16'(k * 9362 + 77), 16'hFE0C, 16'd3000, 0);
    end
    queue_request(16'h5555, 16'h2AAA, 16'hD555, 0);
    queue_request(16'hAAAA, 16'hD555, 16'h2AAA, 0);
    queue_random_set(0);

    // Full-scale bus reciprocal and period: clamping on both sides
    queue_settings(24'd1, 24'd0, 24'hFFFFFF, 24'd65535);
    queue_random_set(71);
    // No pole pairs: angle comes from the offset alone
    queue_settings(24'd0, 24'd65535, 24'd256, 24'd1);
    queue_random_set(26);
    // No bus reciprocal: every duty sits at one half
    queue_settings(24'd64, 24'($urandom), 24'd0, 24'($urandom_range(65535, 1)));
    queue_random_set(0);
    // No period: all compares zero
    queue_settings(24'd127, 24'($urandom), 24'($urandom), 24'd0);
    queue_random_set(71);
    queue_settings(24'($urandom_range(64, 1)), 24'($urandom),
                   24'($urandom_range(20000, 256)), 24'($urandom_range(65535, 1)));
    queue_random_set(26);
    // Junk in the unused upper bits of narrow registers
    queue_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    queue_random_set(0);
    queue_settings(POLES_RST, OFFSET_RST, RECIP_RST, PERIOD_RST);
    queue_random_set(71);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_q.size() != 0 || start_i || compares_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && compares_due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Request driver: hold a request until it is taken, pause before register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i      <= 1'b0;
      cfg_we_i     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= start_i ? 0 : quiet_cycles + 1;
      if (start_i && busy_o !== 1'b0) begin
        // hold
        cfg_we_i <= 1'b0;
      end else if (job_q.size() == 0) begin
        start_i  <= 1'b0;
        cfg_we_i <= 1'b0;
      end else if (job_q[0].is_write) begin
        start_i <= 1'b0;
        if (quiet_cycles >= SETTLE_CYCLES && compares_due_q.size() == 0) begin
          cfg_we_i    <= 1'b1;
          cfg_idx_i   <= job_q[0].cfg_sel;
          cfg_wdata_i <= job_q[0].value;
          void'(job_q.pop_front());
        end else begin
          cfg_we_i <= 1'b0;
        end
      end else if ($urandom_range(99) < job_q[0].idle_pct) begin
        start_i  <= 1'b0;
        cfg_we_i <= 1'b0;
        req_i    <= fvtp_req_t'(48'({$urandom, $urandom}));
      end else begin
        start_i  <= 1'b1;
        cfg_we_i <= 1'b0;
        req_i    <= job_q[0].req;
        void'(job_q.pop_front());
      end
    end
  end

  // Result monitor: check results, track register writes, predict each taken request
  always @(posedge clk_i or negedge rst_ni) begin
    fvtp_res_t due;
    if (!rst_ni) begin
      poles_m  <= POLES_RST;
      offset_m <= OFFSET_RST;
      recip_m  <= RECIP_RST;
      period_m <= PERIOD_RST;
    end else begin
      if (done_o === 1'b1) begin
        if (compares_due_q.size() == 0) begin
          note_failure($sformatf("result with no request pending: a=%0d b=%0d c=%0d",
                                 result_o.compare_a, result_o.compare_b,
                                 result_o.compare_c));
        end else begin
          due = compares_due_q.pop_front();
          if (result_o.compare_a !== due.compare_a || result_o.compare_b !== due.compare_b
              || result_o.compare_c !== due.compare_c) begin
            note_failure($sformatf("compare mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                                   due.compare_a, due.compare_b, due.compare_c,
                                   result_o.compare_a, result_o.compare_b,
                                   result_o.compare_c));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLE_PAIRS:     poles_m  <= longint'(cfg_wdata_i[POLE_W-1:0]);
          CFG_ANGLE_OFFSET:   offset_m <= longint'(cfg_wdata_i[ANGLE_BITS-1:0]);
          CFG_BUS_RECIPROCAL: recip_m  <= longint'(cfg_wdata_i[RECIP_W-1:0]);
          CFG_PWM_PERIOD:     period_m <= longint'(cfg_wdata_i[CMP_W-1:0]);
          default: ;
        endcase
      end
      if (start_i && busy_o === 1'b0) compares_due_q.push_back(predict_compares(req_i));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
